/* rtl/core/rme_pkg.sv */
`default_nettype none

package rme_pkg;

   // Fixed-point formats
   localparam int MAT_FRAC = 14;
   localparam int ANG_FRAC = 12;
   localparam int IN_W     = 16;
   localparam int OUT_W    = 15;
   localparam int MAG_W    = 16;

   // Square-root and divider chains
   localparam int SQ_W      = 32;
   localparam int RT_W      = 16;
   localparam int SQ_STEPS  = RT_W;
   localparam int Q_W       = 15;
   localparam int DIV_STEPS = Q_W;

   localparam logic signed [IN_W-1:0] UNIT_S  = IN_W'(2 ** MAT_FRAC);
   localparam logic [Q_W-1:0]         UNIT_Q  = Q_W'(2 ** MAT_FRAC);
   localparam logic [SQ_W-1:0]        UNIT_SQ = SQ_W'(1) << (2 * MAT_FRAC);

   // CORDIC datapath
   localparam int LANES       = 3;
   localparam int LANE_PITCH  = 0;
   localparam int LANE_YAW    = 1;
   localparam int LANE_ROLL   = 2;
   localparam int PRESCALE_SH = 32;
   localparam int XY_W        = 52;
   localparam int ANG_W       = 35;
   localparam int ATAN_LEN    = 24;

   localparam logic signed [ANG_W-1:0] Q30_PI      = 35'sd3373259426;
   localparam logic signed [ANG_W-1:0] Q30_HALF_PI = 35'sd1686629713;
   localparam int OUT_SH = 30 - ANG_FRAC;
   localparam logic signed [ANG_W-1:0] ROUND_HALF  = ANG_W'(1) <<< (OUT_SH - 1);
   localparam logic signed [ANG_W-1:0] OUT_LIM     = (Q30_PI + ROUND_HALF) >>> OUT_SH;

   localparam logic signed [ANG_W-1:0] ATAN_TAB [ATAN_LEN] = '{
      35'sd843314857, 35'sd497837829, 35'sd263043837, 35'sd133525159,
      35'sd67021687,  35'sd33543516,  35'sd16775851,  35'sd8388437,
      35'sd4194283,   35'sd2097149,   35'sd1048576,   35'sd524288,
      35'sd262144,    35'sd131072,    35'sd65536,     35'sd32768,
      35'sd16384,     35'sd8192,      35'sd4096,      35'sd2048,
      35'sd1024,      35'sd512,       35'sd256,       35'sd128
   };

   typedef struct packed {
      logic signed [XY_W-1:0]  x;
      logic signed [XY_W-1:0]  y;
      logic signed [ANG_W-1:0] z;
   } cvec_type;

endpackage

`default_nettype wire

/* rtl/core/rme_sqrt_cell.sv */
`default_nettype none

module rme_sqrt_cell import rme_pkg::*; #(
   parameter int BIT = 0
) (
   input  logic            clock,
   input  logic            en,
   input  logic [SQ_W-1:0] rem_src,
   input  logic [RT_W-1:0] root_src,
   output logic [SQ_W-1:0] rem_dst,
   output logic [RT_W-1:0] root_dst
);

   logic [SQ_W+1:0] trial;
   logic            fit;
   logic [SQ_W-1:0] rem_in, rem_ff;
   logic [RT_W-1:0] root_in, root_ff;

   // (root + 2^b)^2 - root^2
   assign trial = ({2'b00, SQ_W'(root_src)} << (BIT + 1)) | ((SQ_W + 2)'(1) << (2 * BIT));
   assign fit   = {2'b00, rem_src} >= trial;

   always_comb begin
      rem_in  = fit ? rem_src - trial[SQ_W-1:0] : rem_src;
      root_in = fit ? root_src | (RT_W'(1) << BIT) : root_src;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign rem_dst  = rem_ff;
   assign root_dst = root_ff;

endmodule

`default_nettype wire

/* rtl/core/rme_div_cell.sv */
`default_nettype none

module rme_div_cell import rme_pkg::*; #(
   parameter int BIT = 0
) (
   input  logic            clock,
   input  logic            en,
   input  logic [SQ_W-1:0] rem_src,
   input  logic [RT_W-1:0] den_src,
   input  logic [Q_W-1:0]  q_src,
   output logic [SQ_W-1:0] rem_dst,
   output logic [RT_W-1:0] den_dst,
   output logic [Q_W-1:0]  q_dst
);

   logic [SQ_W-1:0] trial;
   logic            fit;
   logic [SQ_W-1:0] rem_in, rem_ff;
   logic [RT_W-1:0] den_ff;
   logic [Q_W-1:0]  q_in, q_ff;

   assign trial = SQ_W'(den_src) << BIT;
   assign fit   = rem_src >= trial;

   always_comb begin
      rem_in = fit ? rem_src - trial : rem_src;
      q_in   = fit ? q_src | (Q_W'(1) << BIT) : q_src;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         den_ff <= den_src;
         q_ff   <= q_in;
      end
   end

   assign rem_dst = rem_ff;
   assign den_dst = den_ff;
   assign q_dst   = q_ff;

endmodule

`default_nettype wire

/* rtl/core/rme_cordic_cell.sv */
`default_nettype none

module rme_cordic_cell import rme_pkg::*; #(
   parameter int STEP = 0
) (
   input  logic                     clock,
   input  logic                     en,
   input  cvec_type [LANES-1:0]     vec_src,
   output cvec_type [LANES-1:0]     vec_dst
);

   localparam logic signed [ANG_W-1:0] ATAN_STEP = ATAN_TAB[STEP];

   logic signed [XY_W-1:0]  xs [LANES];
   logic signed [XY_W-1:0]  ys [LANES];
   logic signed [ANG_W-1:0] zs [LANES];
   cvec_type [LANES-1:0]    vec_in, vec_ff;

   // Rotate each lane toward the x axis; leave a lane with y == 0 untouched.
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         xs[l] = vec_src[l].x;
         ys[l] = vec_src[l].y;
         zs[l] = vec_src[l].z;
         vec_in[l] = vec_src[l];
         if (!ys[l][XY_W-1] && (ys[l] != '0)) begin
            vec_in[l].x = xs[l] + (ys[l] >>> STEP);
            vec_in[l].y = ys[l] - (xs[l] >>> STEP);
            vec_in[l].z = zs[l] + ATAN_STEP;
         end else if (ys[l][XY_W-1]) begin
            vec_in[l].x = xs[l] - (ys[l] >>> STEP);
            vec_in[l].y = ys[l] + (xs[l] >>> STEP);
            vec_in[l].z = zs[l] - ATAN_STEP;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vec_ff <= vec_in;
      end
   end

   assign vec_dst = vec_ff;

endmodule

`default_nettype wire

/* rtl/core/rotation_matrix_to_euler.sv */
`default_nettype none

// Rotation matrix to Euler angles. Each transaction carries the forward
// column, the right column and the z of the up column in signed Q1.14 and
// returns pitch, yaw and roll in signed Q2.12 radians, saturated at +-pi,
// plus a degenerate flag when forward has no horizontal length (yaw and roll
// are then 0). The block is one pipeline of small cells: a product stage and
// a sum stage, a 16-cell square-root chain for the horizontal length with a
// twin chain beside it for the pitch complement, a 15-cell divider chain for
// the normalized roll dot product, three stages that clamp and square the
// quotient, a second 16-cell square-root chain for the roll complement, and
// a CORDIC_STEPS-cell vectoring CORDIC chain that resolves all three angles
// side by side, then three stages of folding and rounding. It takes one
// transaction per cycle; when the result side stalls, the whole pipeline
// holds and req_ready drops with it.

module rotation_matrix_to_euler import rme_pkg::*; #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic signed [IN_W-1:0]  req_fwd_x,
   input  logic signed [IN_W-1:0]  req_fwd_y,
   input  logic signed [IN_W-1:0]  req_fwd_z,
   input  logic signed [IN_W-1:0]  req_rgt_x,
   input  logic signed [IN_W-1:0]  req_rgt_y,
   input  logic signed [IN_W-1:0]  req_rgt_z,
   input  logic signed [IN_W-1:0]  req_upv_z,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [OUT_W-1:0] rsp_pitch_out,
   output logic signed [OUT_W-1:0] rsp_yaw_out,
   output logic signed [OUT_W-1:0] rsp_roll_out,
   output logic                    rsp_degenerate
);

   localparam int LAT = 2 + SQ_STEPS + DIV_STEPS + 3 + SQ_STEPS + CORDIC_STEPS + 3;
   localparam int PAD = XY_W - MAG_W - PRESCALE_SH;

   // Side information that rides along with each transaction
   typedef struct packed {
      logic [MAG_W-1:0] fx_abs;
      logic [MAG_W-1:0] fy_abs;
      logic [Q_W-1:0]   pz_abs;
      logic             fx_neg;
      logic             fy_neg;
      logic             pz_neg;
      logic             rz_neg;
      logic             uz_neg;
      logic             degen;
      logic [SQ_W-1:0]  n_abs;
      logic             n_neg;
      logic [RT_W-1:0]  pitch_x;
      logic             ovf;
      logic [Q_W-1:0]   d_abs;
      logic             d_neg;
   } ctx_type;

   function automatic logic signed [OUT_W-1:0] to_out(input logic signed [ANG_W-1:0] v);
      logic signed [ANG_W-1:0] r;
      r = (v + ROUND_HALF) >>> OUT_SH;
      if (r > OUT_LIM) begin
         r = OUT_LIM;
      end else if (r < -OUT_LIM) begin
         r = -OUT_LIM;
      end
      return r[OUT_W-1:0];
   endfunction

   // Global advance: hold every stage while the result register is stalled.
   logic           en;
   logic [LAT-1:0] vld_ff;

   assign en        = !vld_ff[LAT-1] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], req_valid};
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: clamp forward z, take magnitudes, form the products.
   // ---------------------------------------------------------------------
   logic signed [IN_W-1:0]   pz;
   logic signed [2*IN_W-1:0] p_xx_in, p_yy_in, p_xr_in, p_yr_in, p_zz_in;
   logic signed [2*IN_W-1:0] p_xx_ff, p_yy_ff, p_xr_ff, p_yr_ff, p_zz_ff;
   ctx_type                  ctx_s1_in, ctx_s1_ff;

   always_comb begin
      if (req_fwd_z > UNIT_S) begin
         pz = UNIT_S;
      end else if (req_fwd_z < -UNIT_S) begin
         pz = -UNIT_S;
      end else begin
         pz = req_fwd_z;
      end
      p_xx_in = req_fwd_x * req_fwd_x;
      p_yy_in = req_fwd_y * req_fwd_y;
      p_xr_in = req_fwd_x * req_rgt_y;
      p_yr_in = req_fwd_y * req_rgt_x;
      p_zz_in = pz * pz;

      ctx_s1_in        = '0;
      ctx_s1_in.fx_neg = req_fwd_x[IN_W-1];
      ctx_s1_in.fy_neg = req_fwd_y[IN_W-1];
      ctx_s1_in.pz_neg = pz[IN_W-1];
      ctx_s1_in.rz_neg = req_rgt_z[IN_W-1];
      ctx_s1_in.uz_neg = req_upv_z[IN_W-1];
      ctx_s1_in.fx_abs = req_fwd_x[IN_W-1] ? MAG_W'(-req_fwd_x) : MAG_W'(req_fwd_x);
      ctx_s1_in.fy_abs = req_fwd_y[IN_W-1] ? MAG_W'(-req_fwd_y) : MAG_W'(req_fwd_y);
      ctx_s1_in.pz_abs = pz[IN_W-1] ? Q_W'(-pz) : Q_W'(pz);
      ctx_s1_in.degen  = (req_fwd_x == '0) && (req_fwd_y == '0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_xx_ff   <= p_xx_in;
         p_yy_ff   <= p_yy_in;
         p_xr_ff   <= p_xr_in;
         p_yr_ff   <= p_yr_in;
         p_zz_ff   <= p_zz_in;
         ctx_s1_ff <= ctx_s1_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: squared horizontal length, cross term magnitude and sign,
   // pitch radicand.
   // ---------------------------------------------------------------------
   logic                     n_lt;
   logic signed [2*IN_W:0]   diff_a, diff_b;
   logic [SQ_W-1:0]          hsum_in, hsum_ff, prad_in, prad_ff;
   ctx_type                  ctx_s2_in, ctx_s2_ff;

   always_comb begin
      n_lt    = p_xr_ff < p_yr_ff;
      diff_a  = {p_xr_ff[2*IN_W-1], p_xr_ff} - {p_yr_ff[2*IN_W-1], p_yr_ff};
      diff_b  = {p_yr_ff[2*IN_W-1], p_yr_ff} - {p_xr_ff[2*IN_W-1], p_xr_ff};
      hsum_in = unsigned'(p_xx_ff) + unsigned'(p_yy_ff);
      prad_in = UNIT_SQ - unsigned'(p_zz_ff);

      ctx_s2_in       = ctx_s1_ff;
      ctx_s2_in.n_abs = n_lt ? diff_b[SQ_W-1:0] : diff_a[SQ_W-1:0];
      // Flip the sign when up z is negative.
      ctx_s2_in.n_neg = n_lt ^ ctx_s1_ff.uz_neg;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hsum_ff   <= hsum_in;
         prad_ff   <= prad_in;
         ctx_s2_ff <= ctx_s2_in;
      end
   end

   // ---------------------------------------------------------------------
   // Square-root chains: horizontal length and pitch complement.
   // ---------------------------------------------------------------------
   logic [SQ_W-1:0] hrem  [SQ_STEPS+1];
   logic [RT_W-1:0] hroot [SQ_STEPS+1];
   logic [SQ_W-1:0] prem  [SQ_STEPS+1];
   logic [RT_W-1:0] proot [SQ_STEPS+1];

   assign hrem[0]  = hsum_ff;
   assign hroot[0] = '0;
   assign prem[0]  = prad_ff;
   assign proot[0] = '0;

   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt_a
      rme_sqrt_cell #(.BIT(SQ_STEPS - 1 - k)) u_h (
         .clock    (clock),
         .en       (en),
         .rem_src  (hrem[k]),
         .root_src (hroot[k]),
         .rem_dst  (hrem[k+1]),
         .root_dst (hroot[k+1])
      );
      rme_sqrt_cell #(.BIT(SQ_STEPS - 1 - k)) u_p (
         .clock    (clock),
         .en       (en),
         .rem_src  (prem[k]),
         .root_src (proot[k]),
         .rem_dst  (prem[k+1]),
         .root_dst (proot[k+1])
      );
   end

   ctx_type ctx_a_ff [SQ_STEPS];

   always_ff @(posedge clock) begin
      if (en) begin
         ctx_a_ff[0] <= ctx_s2_ff;
         for (int k = 1; k < SQ_STEPS; k++) begin
            ctx_a_ff[k] <= ctx_a_ff[k-1];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Divider chain: |n| / h, one quotient bit per cell. Flag a quotient that
   // cannot fit; the clamp to one catches it.
   // ---------------------------------------------------------------------
   ctx_type         ctx_b_in;
   logic [SQ_W-1:0] drem [DIV_STEPS+1];
   logic [RT_W-1:0] dden [DIV_STEPS+1];
   logic [Q_W-1:0]  dq   [DIV_STEPS+1];

   always_comb begin
      ctx_b_in         = ctx_a_ff[SQ_STEPS-1];
      ctx_b_in.pitch_x = proot[SQ_STEPS];
      ctx_b_in.ovf     = (ctx_a_ff[SQ_STEPS-1].n_abs >> DIV_STEPS) >= SQ_W'(hroot[SQ_STEPS]);
   end

   assign drem[0] = ctx_a_ff[SQ_STEPS-1].n_abs;
   assign dden[0] = hroot[SQ_STEPS];
   assign dq[0]   = '0;

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      rme_div_cell #(.BIT(DIV_STEPS - 1 - k)) u_d (
         .clock   (clock),
         .en      (en),
         .rem_src (drem[k]),
         .den_src (dden[k]),
         .q_src   (dq[k]),
         .rem_dst (drem[k+1]),
         .den_dst (dden[k+1]),
         .q_dst   (dq[k+1])
      );
   end

   ctx_type ctx_b_ff [DIV_STEPS];

   always_ff @(posedge clock) begin
      if (en) begin
         ctx_b_ff[0] <= ctx_b_in;
         for (int k = 1; k < DIV_STEPS; k++) begin
            ctx_b_ff[k] <= ctx_b_ff[k-1];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Clamp the dot product, square it, form the roll radicand.
   // ---------------------------------------------------------------------
   ctx_type           ctx_c_in, ctx_c_ff, ctx_q_ff, ctx_r_ff;
   logic [2*Q_W-1:0]  dsq_in, dsq_ff;
   logic [SQ_W-1:0]   drad_in, drad_ff;
   logic [Q_W-1:0]    q_fin;
   logic              ovf_fin;

   always_comb begin
      q_fin          = dq[DIV_STEPS];
      ovf_fin        = ctx_b_ff[DIV_STEPS-1].ovf;
      ctx_c_in       = ctx_b_ff[DIV_STEPS-1];
      ctx_c_in.d_abs = (ovf_fin || (q_fin > UNIT_Q)) ? UNIT_Q : q_fin;
      // A zero quotient counts as non-negative.
      ctx_c_in.d_neg = ctx_b_ff[DIV_STEPS-1].n_neg && (ovf_fin || (q_fin != '0));
      dsq_in         = ctx_c_ff.d_abs * ctx_c_ff.d_abs;
      drad_in        = UNIT_SQ - SQ_W'(dsq_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctx_c_ff <= ctx_c_in;
         dsq_ff   <= dsq_in;
         ctx_q_ff <= ctx_c_ff;
         drad_ff  <= drad_in;
         ctx_r_ff <= ctx_q_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Square-root chain: roll complement.
   // ---------------------------------------------------------------------
   logic [SQ_W-1:0] rrem  [SQ_STEPS+1];
   logic [RT_W-1:0] rroot [SQ_STEPS+1];

   assign rrem[0]  = drad_ff;
   assign rroot[0] = '0;

   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt_b
      rme_sqrt_cell #(.BIT(SQ_STEPS - 1 - k)) u_r (
         .clock    (clock),
         .en       (en),
         .rem_src  (rrem[k]),
         .root_src (rroot[k]),
         .rem_dst  (rrem[k+1]),
         .root_dst (rroot[k+1])
      );
   end

   ctx_type ctx_e_ff [SQ_STEPS];

   always_ff @(posedge clock) begin
      if (en) begin
         ctx_e_ff[0] <= ctx_r_ff;
         for (int k = 1; k < SQ_STEPS; k++) begin
            ctx_e_ff[k] <= ctx_e_ff[k-1];
         end
      end
   end

   // ---------------------------------------------------------------------
   // CORDIC chain, three lanes side by side.
   // ---------------------------------------------------------------------
   cvec_type [LANES-1:0] cv [CORDIC_STEPS+1];
   ctx_type              ctx_e_last;

   assign ctx_e_last = ctx_e_ff[SQ_STEPS-1];

   always_comb begin
      cv[0][LANE_PITCH].x = {{PAD{1'b0}}, ctx_e_last.pitch_x, {PRESCALE_SH{1'b0}}};
      cv[0][LANE_PITCH].y = {{PAD{1'b0}}, MAG_W'(ctx_e_last.pz_abs), {PRESCALE_SH{1'b0}}};
      cv[0][LANE_PITCH].z = '0;
      cv[0][LANE_YAW].x   = {{PAD{1'b0}}, ctx_e_last.fx_abs, {PRESCALE_SH{1'b0}}};
      cv[0][LANE_YAW].y   = {{PAD{1'b0}}, ctx_e_last.fy_abs, {PRESCALE_SH{1'b0}}};
      cv[0][LANE_YAW].z   = '0;
      cv[0][LANE_ROLL].x  = {{PAD{1'b0}}, MAG_W'(ctx_e_last.d_abs), {PRESCALE_SH{1'b0}}};
      cv[0][LANE_ROLL].y  = {{PAD{1'b0}}, rroot[SQ_STEPS], {PRESCALE_SH{1'b0}}};
      cv[0][LANE_ROLL].z  = '0;
   end

   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
      rme_cordic_cell #(.STEP(k)) u_c (
         .clock   (clock),
         .en      (en),
         .vec_src (cv[k]),
         .vec_dst (cv[k+1])
      );
   end

   ctx_type ctx_d_ff [CORDIC_STEPS];

   always_ff @(posedge clock) begin
      if (en) begin
         ctx_d_ff[0] <= ctx_e_last;
         for (int k = 1; k < CORDIC_STEPS; k++) begin
            ctx_d_ff[k] <= ctx_d_ff[k-1];
         end
      end
   end

   // ---------------------------------------------------------------------
   // F1: clamp each angle to [0, pi/2], fold yaw and roll into [0, pi].
   // ---------------------------------------------------------------------
   logic signed [ANG_W-1:0] zc [LANES];
   logic signed [ANG_W-1:0] ap_in, ay_in, ar_in, ap_ff, ay_ff, ar_ff;
   ctx_type                 ctx_d_last, ctx_f1_ff;

   assign ctx_d_last = ctx_d_ff[CORDIC_STEPS-1];

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         zc[l] = cv[CORDIC_STEPS][l].z;
         if (zc[l] < 0) begin
            zc[l] = '0;
         end else if (zc[l] > Q30_HALF_PI) begin
            zc[l] = Q30_HALF_PI;
         end
      end
      ap_in = zc[LANE_PITCH];
      ay_in = ctx_d_last.fx_neg ? Q30_PI - zc[LANE_YAW] : zc[LANE_YAW];
      ar_in = ctx_d_last.d_neg ? Q30_PI - zc[LANE_ROLL] : zc[LANE_ROLL];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ap_ff     <= ap_in;
         ay_ff     <= ay_in;
         ar_ff     <= ar_in;
         ctx_f1_ff <= ctx_d_last;
      end
   end

   // ---------------------------------------------------------------------
   // F2: apply signs and the roll quadrant fold; drop yaw and roll when
   // forward is vertical.
   // ---------------------------------------------------------------------
   logic signed [ANG_W-1:0] pitch_in, yaw_in, roll_in, pitch_ff, yaw_ff, roll_ff;
   logic                    degen_f2_ff;

   always_comb begin
      pitch_in = ctx_f1_ff.pz_neg ? -ap_ff : ap_ff;
      yaw_in   = ctx_f1_ff.fy_neg ? -ay_ff : ay_ff;
      unique case ({ctx_f1_ff.rz_neg, ctx_f1_ff.uz_neg})
         2'b00:   roll_in = -ar_ff;
         2'b01:   roll_in = ar_ff - Q30_PI;
         2'b11:   roll_in = Q30_PI - ar_ff;
         default: roll_in = ar_ff;
      endcase
      if (ctx_f1_ff.degen) begin
         yaw_in  = '0;
         roll_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pitch_ff    <= pitch_in;
         yaw_ff      <= yaw_in;
         roll_ff     <= roll_in;
         degen_f2_ff <= ctx_f1_ff.degen;
      end
   end

   // ---------------------------------------------------------------------
   // F3: round to the output scale and saturate into the result register.
   // ---------------------------------------------------------------------
   logic signed [OUT_W-1:0] pitch_out_ff, yaw_out_ff, roll_out_ff;
   logic                    degen_out_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         pitch_out_ff <= to_out(pitch_ff);
         yaw_out_ff   <= to_out(yaw_ff);
         roll_out_ff  <= to_out(roll_ff);
         degen_out_ff <= degen_f2_ff;
      end
   end

   assign rsp_pitch_out  = pitch_out_ff;
   assign rsp_yaw_out    = yaw_out_ff;
   assign rsp_roll_out   = roll_out_ff;
   assign rsp_degenerate = degen_out_ff;

endmodule

`default_nettype wire

/* tb/rotation_matrix_to_euler_tb.sv */
`timescale 1ns / 1ps

module rotation_matrix_to_euler_tb;
   import rme_pkg::*;

   // One matrix transaction as the block sees it.
   typedef struct {
      logic signed [IN_W-1:0] fx, fy, fz, rx, ry, rz, uz;
   } matrix_type;

   // One set of angles as the block returns it.
   typedef struct packed {
      logic [OUT_W-1:0] pitch, yaw, roll;
      logic             degen;
   } angles_type;

   // Pending-angle scoreboard: predict on accept, compare on result.
   class angle_board;
      angles_type pending[$];
      int      mismatches = 0;
      int      checked = 0;
      int      degen_seen = 0;

      function longint unsigned int_sqrt(longint unsigned v);
         longint unsigned res, bit_w;
         res = 0;
         bit_w = 64'd1 << 62;
         while (bit_w > v) bit_w >>= 2;
         while (bit_w != 0) begin
            if (v >= res + bit_w) begin
               v = v - (res + bit_w);
               res = (res >> 1) + bit_w;
            end else begin
               res >>= 1;
            end
            bit_w >>= 2;
         end
         return res;
      endfunction

      // Vectoring rotation of (x0, y0), first quadrant, angle in Q30.
      function longint vector_angle(longint x0, longint y0);
         longint x, y, z, dx, dy;
         x = x0 <<< PRESCALE_SH;
         y = y0 <<< PRESCALE_SH;
         z = 0;
         for (int i = 0; i < 16 && i < ATAN_LEN; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
               x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
            end else if (y < 0) begin
               x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
            end
         end
         if (z < 0) z = 0;
         if (z > longint'(Q30_HALF_PI)) z = longint'(Q30_HALF_PI);
         return z;
      endfunction

      function logic [OUT_W-1:0] round_out(longint q30);
         longint half, lim, r;
         half = longint'(1) <<< (OUT_SH - 1);
         lim = (longint'(Q30_PI) + half) >>> OUT_SH;
         r = (q30 + half) >>> OUT_SH;
         if (r > lim) r = lim;
         if (r < -lim) r = -lim;
         return r[OUT_W-1:0];
      endfunction

      function longint mag(longint v);
         return v < 0 ? -v : v;
      endfunction

      function void note(matrix_type m);
         longint fx, fy, fz, rx, ry, rz, uz, one, pz, a, h, n, d, c;
         longint pitch, yaw, roll;
         angles_type e;
         fx = m.fx; fy = m.fy; fz = m.fz;
         rx = m.rx; ry = m.ry; rz = m.rz; uz = m.uz;
         one = longint'(1) << MAT_FRAC;
         yaw = 0;
         roll = 0;
         e.degen = 1'b0;
         pz = fz > one ? one : (fz < -one ? -one : fz);
         a = vector_angle(longint'(int_sqrt(one * one - pz * pz)), mag(pz));
         pitch = pz < 0 ? -a : a;
         if (fx == 0 && fy == 0) begin
            e.degen = 1'b1;
         end else begin
            a = vector_angle(mag(fx), mag(fy));
            if (fx < 0) a = longint'(Q30_PI) - a;
            yaw = fy < 0 ? -a : a;
            h = longint'(int_sqrt(fx * fx + fy * fy));
            n = fx * ry - fy * rx;
            if (uz < 0) n = -n;
            d = n / h;
            if (d > one) d = one;
            if (d < -one) d = -one;
            c = vector_angle(mag(d), longint'(int_sqrt(one * one - d * d)));
            if (d < 0) c = longint'(Q30_PI) - c;
            // Fold roll by the quadrant of right z and up z.
            if (rz >= 0) roll = (uz >= 0) ? -c : c - longint'(Q30_PI);
            else         roll = (uz < 0) ? longint'(Q30_PI) - c : c;
         end
         e.pitch = round_out(pitch);
         e.yaw = round_out(yaw);
         e.roll = round_out(roll);
         pending.push_back(e);
      endfunction

      function void check(angles_type got);
         angles_type e;
         checked++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result pitch=%0d", got.pitch);
            return;
         end
         e = pending.pop_front();
         if (got.degen) degen_seen++;
         if (got !== e) begin
            mismatches++;
            if (mismatches <= 10)
               $display("angle error: exp p=%h y=%h r=%h dg=%b got p=%h y=%h r=%h dg=%b",
                        e.pitch, e.yaw, e.roll, e.degen,
                        got.pitch, got.yaw, got.roll, got.degen);
         end
      endfunction
   endclass

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic signed [IN_W-1:0]  req_fwd_x, req_fwd_y, req_fwd_z;
   logic signed [IN_W-1:0]  req_rgt_x, req_rgt_y, req_rgt_z, req_upv_z;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic signed [OUT_W-1:0] rsp_pitch_out, rsp_yaw_out, rsp_roll_out;
   logic                    rsp_degenerate;

   angle_board board;
   int  sent = 0;
   bit  calm = 0;      // no idling on either side while set
   bit  hold_done = 0;

   rotation_matrix_to_euler DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_fwd_x(req_fwd_x), .req_fwd_y(req_fwd_y), .req_fwd_z(req_fwd_z),
      .req_rgt_x(req_rgt_x), .req_rgt_y(req_rgt_y), .req_rgt_z(req_rgt_z),
      .req_upv_z(req_upv_z),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_pitch_out(rsp_pitch_out), .rsp_yaw_out(rsp_yaw_out),
      .rsp_roll_out(rsp_roll_out), .rsp_degenerate(rsp_degenerate)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Drive one matrix transaction and hold it until accepted.
   task automatic send_matrix(matrix_type m);
      while (!calm && $urandom_range(0, 99) < 20) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_fwd_x <= m.fx; req_fwd_y <= m.fy; req_fwd_z <= m.fz;
      req_rgt_x <= m.rx; req_rgt_y <= m.ry; req_rgt_z <= m.rz;
      req_upv_z <= m.uz;
      forever begin
         @(posedge clock);
         if (req_ready) break;
      end
      board.note(m);
      sent++;
      @(negedge clock);
   endtask

   function automatic logic signed [IN_W-1:0] any_comp();
      case ($urandom_range(0, 5))
         0: return IN_W'(16384);
         1: return -IN_W'(16384);
         2: return 0;
         3: return IN_W'($signed($urandom_range(0, 8)) - 4);
         default: return IN_W'($signed($urandom_range(0, 32768)) - 16384);
      endcase
   endfunction

   function automatic logic signed [IN_W-1:0] to_q14(real v);
      int q;
      q = $rtoi(v * 16384.0 + (v >= 0 ? 0.5 : -0.5));
      if (q > 16384) q = 16384;
      if (q < -16384) q = -16384;
      return IN_W'(q);
   endfunction

   // Build a proper rotation from random yaw, pitch and roll.
   function automatic matrix_type rotation();
      real y, p, r, cy, sy, cp, sp, cr, sr;
      matrix_type m;
      y = $urandom_range(0, 62831) / 10000.0 - 3.14159;
      p = $urandom_range(0, 31415) / 10000.0 - 1.5708;
      r = $urandom_range(0, 62831) / 10000.0 - 3.14159;
      cy = $cos(y); sy = $sin(y); cp = $cos(p); sp = $sin(p);
      cr = $cos(r); sr = $sin(r);
      m.fx = to_q14(cy * cp);
      m.fy = to_q14(sy * cp);
      m.fz = to_q14(-sp);
      m.rx = to_q14(cy * sp * sr - sy * cr);
      m.ry = to_q14(sy * sp * sr + cy * cr);
      m.rz = to_q14(cp * sr);
      m.uz = to_q14(cp * cr);
      return m;
   endfunction

   function automatic matrix_type mk(int fx, int fy, int fz, int rx, int ry, int rz, int uz);
      matrix_type m;
      m.fx = IN_W'(fx); m.fy = IN_W'(fy); m.fz = IN_W'(fz);
      m.rx = IN_W'(rx); m.ry = IN_W'(ry); m.rz = IN_W'(rz); m.uz = IN_W'(uz);
      return m;
   endfunction

   // Receiver: random stalls, plus one long hold-off to fill the pipe.
   initial begin
      int hold;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!hold_done && sent >= 120) begin
            hold_done = 1;
            rsp_ready <= 1'b0;
            for (hold = 0; hold < 300; hold++) @(negedge clock);
         end
         rsp_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 20);
         @(negedge clock);
      end
   end

   // Result monitor.
   always @(posedge clock) begin
      angles_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.pitch = rsp_pitch_out;
         got.yaw = rsp_yaw_out;
         got.roll = rsp_roll_out;
         got.degen = rsp_degenerate;
         board.check(got);
      end
   end

   initial begin
      #2_000_000;
      $display("rotation_matrix_to_euler: mismatch");
      $finish;
   end

   initial begin
      matrix_type m;
      int wait_n;
      board = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_fwd_x = 0; req_fwd_y = 0; req_fwd_z = 0;
      req_rgt_x = 0; req_rgt_y = 0; req_rgt_z = 0; req_upv_z = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: identity, extremes, degenerate forward, yaw at +pi,
      // right column longer than one, every roll quadrant.
      send_matrix(mk(16384, 0, 0, 0, 16384, 0, 16384));
      send_matrix(mk(0, 0, 16384, 0, 16384, 0, 0));
      send_matrix(mk(0, 0, -16384, 16384, 0, 0, 0));
      send_matrix(mk(0, 0, 0, 0, 0, 0, 0));
      send_matrix(mk(-16384, 0, 0, 0, -16384, 0, 16384));
      send_matrix(mk(-1, 0, 5, 0, 0, 0, -1));
      send_matrix(mk(1, 0, -5, 0, 1, 0, 0));
      send_matrix(mk(0, 16384, 0, -16384, 0, 0, 16384));
      send_matrix(mk(0, -16384, 0, 16384, 0, 0, 16384));
      send_matrix(mk(16384, 16384, 0, -16384, 16384, 0, 16384));
      send_matrix(mk(1, 1, 0, -16384, 16384, 0, 16384));
      send_matrix(mk(-16384, -16384, 16384, 16384, -16384, -16384, -16384));
      send_matrix(mk(16384, 0, 0, 0, 8192, 100, 100));
      send_matrix(mk(16384, 0, 0, 0, 8192, 100, -100));
      send_matrix(mk(16384, 0, 0, 0, 8192, -100, -100));
      send_matrix(mk(16384, 0, 0, 0, 8192, -100, 100));
      send_matrix(mk(16384, 0, 0, 0, -8192, 0, 0));
      send_matrix(mk(-16384, 16384, -16384, -16384, -16384, 16384, -16384));
      send_matrix(mk(11585, -11585, 0, 11585, 11585, -1, 16384));
      send_matrix(mk(-16384, -1, 0, 0, 16384, 0, 16384));

      // Random: mostly true rotations, the rest arbitrary components.
      for (int k = 0; k < 500; k++) begin
         calm = (k >= 250 && k < 330);
         if ($urandom_range(0, 99) < 60) begin
            m = rotation();
         end else begin
            m.fx = any_comp(); m.fy = any_comp(); m.fz = any_comp();
            m.rx = any_comp(); m.ry = any_comp(); m.rz = any_comp();
            m.uz = any_comp();
         end
         send_matrix(m);
      end
      calm = 0;
      req_valid <= 1'b0;

      // Drain, then allow the pipeline latency for stray results.
      wait_n = 0;
      while (board.pending.size() != 0 && wait_n < 100000) begin
         @(posedge clock);
         wait_n++;
      end
      repeat (200) @(posedge clock);

      $display("Sent %0d matrices, checked %0d angle sets (%0d degenerate), %0d errors.",
               sent, board.checked, board.degen_seen, board.mismatches);
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("rotation_matrix_to_euler: match");
      end else begin
         $display("rotation_matrix_to_euler: mismatch");
      end
      $finish;
   end
endmodule
